### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// DNFFP_ASSERT: the property must hold at every rising edge outside reset.
// DNFFP_NEVER: the expression must never be true at a rising edge outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DNFFP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DNFFP_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### hw/rtl/dnffp_pkg.sv
`timescale 1ns / 1ps

package dnffp_pkg;

	localparam int unsigned CFG_ADDR_W = 5;
	localparam int unsigned CFG_DATA_W = 32;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_T1_CORES  = 3'd0;
	localparam reg_idx_t REG_T1_MEMORY = 3'd1;
	localparam reg_idx_t REG_T2_CORES  = 3'd2;
	localparam reg_idx_t REG_T2_MEMORY = 3'd3;
	localparam reg_idx_t REG_T1_POWER  = 3'd4;
	localparam reg_idx_t REG_T2_POWER  = 3'd5;

	typedef logic [1:0] op_code_t;
	localparam op_code_t OP_FILL    = 2'd0;
	localparam op_code_t OP_PLACE   = 2'd1;
	localparam op_code_t OP_DAY_END = 2'd2;

	typedef logic [1:0] node_code_t;
	localparam node_code_t NODE_BOTH = 2'd0;
	localparam node_code_t NODE_A    = 2'd1;
	localparam node_code_t NODE_B    = 2'd2;

	localparam logic [15:0] VM_COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  operation;
		logic [9:0]  vm_cores;
		logic [15:0] vm_memory;
		logic        vm_two_nodes;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [9:0]  server_index;
		logic [1:0]  node_choice;
		logic [47:0] power_cost_total;
	} rsp_t;

	typedef struct packed {
		logic [9:0]  type_one_node_cores;
		logic [15:0] type_one_node_memory;
		logic [9:0]  type_two_node_cores;
		logic [15:0] type_two_node_memory;
		logic [15:0] type_one_power_cost;
		logic [15:0] type_two_power_cost;
	} cfg_t;

	typedef struct packed {
		logic [15:0] vm_count;
		logic [15:0] free_memory_b;
		logic [15:0] free_memory_a;
		logic [9:0]  free_cores_b;
		logic [9:0]  free_cores_a;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_PLACE,
		ST_DAY_END
	} state_t;

endpackage

### hw/rtl/dnffp_ram.sv
`timescale 1ns / 1ps

module dnffp_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 68,
	parameter int unsigned AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/dnffp_cfg.sv
`timescale 1ns / 1ps

module dnffp_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dnffp_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [dnffp_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [dnffp_pkg::CFG_DATA_W-1:0] prdata,
	output logic                             pready,
	output dnffp_pkg::cfg_t                  cfg
);

	dnffp_pkg::cfg_t      cfg_q;
	dnffp_pkg::reg_idx_t  reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				dnffp_pkg::REG_T1_CORES:  cfg_q.type_one_node_cores  <= pwdata[9:0];
				dnffp_pkg::REG_T1_MEMORY: cfg_q.type_one_node_memory <= pwdata[15:0];
				dnffp_pkg::REG_T2_CORES:  cfg_q.type_two_node_cores  <= pwdata[9:0];
				dnffp_pkg::REG_T2_MEMORY: cfg_q.type_two_node_memory <= pwdata[15:0];
				dnffp_pkg::REG_T1_POWER:  cfg_q.type_one_power_cost  <= pwdata[15:0];
				dnffp_pkg::REG_T2_POWER:  cfg_q.type_two_power_cost  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dnffp_pkg::REG_T1_CORES:  prdata = 32'(cfg_q.type_one_node_cores);
			dnffp_pkg::REG_T1_MEMORY: prdata = 32'(cfg_q.type_one_node_memory);
			dnffp_pkg::REG_T2_CORES:  prdata = 32'(cfg_q.type_two_node_cores);
			dnffp_pkg::REG_T2_MEMORY: prdata = 32'(cfg_q.type_two_node_memory);
			dnffp_pkg::REG_T1_POWER:  prdata = 32'(cfg_q.type_one_power_cost);
			dnffp_pkg::REG_T2_POWER:  prdata = 32'(cfg_q.type_two_power_cost);
			default:                  prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/dnffp_engine.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dnffp_engine #(
	parameter int unsigned SERVER_COUNT = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dnffp_pkg::cfg_t cfg,
	input  logic            start,
	output logic            busy,
	input  dnffp_pkg::req_t req,
	output logic            done,
	output dnffp_pkg::rsp_t rsp
);

	localparam int unsigned IW = $clog2(SERVER_COUNT);
	localparam int unsigned EW = $bits(dnffp_pkg::entry_t);
	localparam logic [IW-1:0] LAST_IDX = IW'(SERVER_COUNT - 1);
	localparam logic [IW-1:0] HALF_IDX = IW'(SERVER_COUNT / 2);

	dnffp_pkg::state_t state_q, state_d;
	logic [IW-1:0]     addr_q, addr_d;
	logic              issue_q, issue_d;
	logic              rd_vld_s1;
	logic [IW-1:0]     rd_addr_s1;
	dnffp_pkg::req_t   req_q;
	logic [47:0]       cost_q, cost_d;
	logic              done_q;
	dnffp_pkg::rsp_t   rsp_q, rsp_d;
	logic              rsp_vld;

	logic              ram_we, ram_re;
	logic [IW-1:0]     ram_waddr;
	dnffp_pkg::entry_t ram_wdata;
	logic [EW-1:0]     ram_rdata;

	dnffp_pkg::entry_t rd_e, upd_e, fill_e;
	logic [9:0]        half_cores;
	logic [15:0]       half_mem;
	logic              fit_two, fit_a, fit_b, fit;
	dnffp_pkg::node_code_t node_sel;
	logic              rd_type_two;
	logic [15:0]       power_sel;
	logic [48:0]       cost_sum;
	logic [47:0]       cost_next;
	logic [31:0]       rd_idx_ext;

	dnffp_ram #(
		.DEPTH (SERVER_COUNT),
		.WIDTH (EW),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign rd_e = dnffp_pkg::entry_t'(ram_rdata);

	// Fit check and updated entry for the server under evaluation
	assign half_cores = {1'b0, req_q.vm_cores[9:1]};
	assign half_mem   = {1'b0, req_q.vm_memory[15:1]};
	assign fit_two = (rd_e.free_cores_a >= half_cores) && (rd_e.free_cores_b >= half_cores) &&
		(rd_e.free_memory_a >= half_mem) && (rd_e.free_memory_b >= half_mem);
	assign fit_a = (rd_e.free_cores_a >= req_q.vm_cores) && (rd_e.free_memory_a >= req_q.vm_memory);
	assign fit_b = (rd_e.free_cores_b >= req_q.vm_cores) && (rd_e.free_memory_b >= req_q.vm_memory);
	assign fit   = req_q.vm_two_nodes ? fit_two : (fit_a || fit_b);

	always_comb begin
		upd_e = rd_e;
		if (rd_e.vm_count != dnffp_pkg::VM_COUNT_MAX) begin
			upd_e.vm_count = rd_e.vm_count + 16'd1;
		end
		priority if (req_q.vm_two_nodes) begin
			upd_e.free_cores_a  = rd_e.free_cores_a - half_cores;
			upd_e.free_cores_b  = rd_e.free_cores_b - half_cores;
			upd_e.free_memory_a = rd_e.free_memory_a - half_mem;
			upd_e.free_memory_b = rd_e.free_memory_b - half_mem;
			node_sel = dnffp_pkg::NODE_BOTH;
		end else if (fit_a) begin
			upd_e.free_cores_a  = rd_e.free_cores_a - req_q.vm_cores;
			upd_e.free_memory_a = rd_e.free_memory_a - req_q.vm_memory;
			node_sel = dnffp_pkg::NODE_A;
		end else begin
			upd_e.free_cores_b  = rd_e.free_cores_b - req_q.vm_cores;
			upd_e.free_memory_b = rd_e.free_memory_b - req_q.vm_memory;
			node_sel = dnffp_pkg::NODE_B;
		end
	end

	// Full-capacity entry for the server being filled
	always_comb begin
		fill_e = '0;
		if (addr_q >= HALF_IDX) begin
			fill_e.free_cores_a  = cfg.type_two_node_cores;
			fill_e.free_cores_b  = cfg.type_two_node_cores;
			fill_e.free_memory_a = cfg.type_two_node_memory;
			fill_e.free_memory_b = cfg.type_two_node_memory;
		end else begin
			fill_e.free_cores_a  = cfg.type_one_node_cores;
			fill_e.free_cores_b  = cfg.type_one_node_cores;
			fill_e.free_memory_a = cfg.type_one_node_memory;
			fill_e.free_memory_b = cfg.type_one_node_memory;
		end
	end

	// Saturating cost accumulation
	assign rd_type_two = (rd_addr_s1 >= HALF_IDX);
	assign power_sel   = rd_type_two ? cfg.type_two_power_cost : cfg.type_one_power_cost;
	assign cost_sum    = {1'b0, cost_q} + 49'(power_sel);
	assign cost_next   = cost_sum[48] ? '1 : cost_sum[47:0];
	assign rd_idx_ext  = 32'(rd_addr_s1);

	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		issue_d   = issue_q;
		cost_d    = cost_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = fill_e;
		rsp_vld   = 1'b0;
		rsp_d     = '0;
		unique case (state_q)
			dnffp_pkg::ST_IDLE: begin
				if (start) begin
					addr_d  = '0;
					issue_d = 1'b1;
					unique case (req.operation)
						dnffp_pkg::OP_FILL:    state_d = dnffp_pkg::ST_FILL;
						dnffp_pkg::OP_PLACE:   state_d = dnffp_pkg::ST_PLACE;
						dnffp_pkg::OP_DAY_END: state_d = dnffp_pkg::ST_DAY_END;
						default:               rsp_vld = 1'b1;
					endcase
				end
			end
			dnffp_pkg::ST_FILL: begin
				ram_we = 1'b1;
				addr_d = addr_q + 1'b1;
				if (addr_q == LAST_IDX) begin
					cost_d  = '0;
					rsp_vld = 1'b1;
					state_d = dnffp_pkg::ST_IDLE;
				end
			end
			dnffp_pkg::ST_PLACE: begin
				priority if (rd_vld_s1 && fit) begin
					ram_we                 = 1'b1;
					ram_waddr              = rd_addr_s1;
					ram_wdata              = upd_e;
					rsp_vld                = 1'b1;
					rsp_d.found            = 1'b1;
					rsp_d.server_index     = rd_idx_ext[9:0];
					rsp_d.node_choice      = node_sel;
					state_d                = dnffp_pkg::ST_IDLE;
				end else if (rd_vld_s1 && (rd_addr_s1 == LAST_IDX)) begin
					rsp_vld = 1'b1;
					state_d = dnffp_pkg::ST_IDLE;
				end else if (issue_q) begin
					ram_re  = 1'b1;
					addr_d  = addr_q + 1'b1;
					issue_d = (addr_q != LAST_IDX);
				end else begin
					ram_re = 1'b0;
				end
			end
			dnffp_pkg::ST_DAY_END: begin
				if (rd_vld_s1 && (rd_e.vm_count != '0)) begin
					cost_d = cost_next;
				end
				if (rd_vld_s1 && (rd_addr_s1 == LAST_IDX)) begin
					rsp_vld                = 1'b1;
					rsp_d.power_cost_total = cost_d;
					state_d                = dnffp_pkg::ST_IDLE;
				end
				if (issue_q) begin
					ram_re  = 1'b1;
					addr_d  = addr_q + 1'b1;
					issue_d = (addr_q != LAST_IDX);
				end
			end
			default: state_d = dnffp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dnffp_pkg::ST_IDLE;
			addr_q    <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			cost_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			addr_q    <= addr_d;
			issue_q   <= issue_d;
			rd_vld_s1 <= ram_re;
			cost_q    <= cost_d;
			done_q    <= rsp_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_addr_s1 <= addr_q;
		end
		if (start && !busy) begin
			req_q <= req;
		end
		if (rsp_vld) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = (state_q != dnffp_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`DNFFP_NEVER(a_no_write_in_day_end, clk, arst_n, (state_q == dnffp_pkg::ST_DAY_END) && ram_we, "memory written during day-end scan")
	`DNFFP_ASSERT(a_read_only_in_scan, clk, arst_n, rd_vld_s1 |-> ((state_q == dnffp_pkg::ST_PLACE) || (state_q == dnffp_pkg::ST_DAY_END)), "read data pending outside a scan")
	`DNFFP_ASSERT(a_found_from_place, clk, arst_n, (done_q && rsp_q.found) |-> ($past(state_q) == dnffp_pkg::ST_PLACE), "found reported by a non-place request")
	`DNFFP_NEVER(a_no_req_while_scan_write, clk, arst_n, ram_we && ram_re, "read and write issued in the same cycle")

endmodule

### hw/rtl/dual_node_first_fit_placer_core.sv
`timescale 1ns / 1ps

// Channel   | Handshake            | Payload          | Direction
// request   | start / busy         | req  (req_t)     | in
// result    | done (one-cycle)     | rsp  (rsp_t)     | out
// config    | psel/penable/pwrite  | paddr, pwdata    | in, prdata out, pready tied high
//
// A request is taken when start is high and busy is low; one result follows.
// Fill: one server entry written per cycle, from index 0 up to SERVER_COUNT-1.
// Place: servers are read in index order over the single memory read port until one
//   takes the VM or all are read; day end reads every server; unused code: no scan.
// Reset clears control state and the cost total; server entries hold nothing
// until the first fill. done lasts one cycle and the receiver cannot stall it.

module dual_node_first_fit_placer_core #(
	parameter int unsigned SERVER_COUNT = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  dnffp_pkg::req_t                  req,
	output logic                             done,
	output dnffp_pkg::rsp_t                  rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dnffp_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [dnffp_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [dnffp_pkg::CFG_DATA_W-1:0] prdata,
	output logic                             pready
);

	// Capacities and power costs, held in the register block
	dnffp_pkg::cfg_t cfg;

	dnffp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Scan engine: owns the server memory, walks it at most once per request
	dnffp_engine #(
		.SERVER_COUNT (SERVER_COUNT)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
